[sv/heater_duty_sequencer_assert.svh]
// Assertion macros shared by the heater duty sequencer RTL.
`ifndef HEATER_DUTY_SEQUENCER_ASSERT_SVH
`define HEATER_DUTY_SEQUENCER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define HDS_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("heater sequencer invariant violated");

// Same-cycle implication checked at every clock edge outside reset.
`define HDS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heater sequencer implication violated");

`endif

[sv/hds_pkg.sv]
// Shared types and constants of the heater duty sequencer.
`timescale 1ns / 1ps

package hds_pkg;

	localparam int DutyW  = 7;
	localparam int TicksW = 20;
	localparam int LevelW = 2;
	localparam int CfgIdxW = 3;

	localparam logic [DutyW-1:0] DutyMax = 7'd100;

	// Command codes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_ON    = 2'd1,
		OP_OFF   = 2'd2,
		OP_LEVEL = 2'd3
	} opcode_t;

	// Sequencing phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_STABLE  = 2'd1,
		PH_FULL    = 2'd2,
		PH_REDUCED = 2'd3
	} phase_t;

	// Heat levels
	localparam logic [LevelW-1:0] LVL_LOW  = 2'd0;
	localparam logic [LevelW-1:0] LVL_MID  = 2'd1;
	localparam logic [LevelW-1:0] LVL_HIGH = 2'd2;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_HIGH_FULL    = 3'd0,
		REG_HIGH_REDUCED = 3'd1,
		REG_MID_FULL     = 3'd2,
		REG_MID_REDUCED  = 3'd3,
		REG_LOW_FULL     = 3'd4,
		REG_LOW_REDUCED  = 3'd5,
		REG_STABLE_TICKS = 3'd6,
		REG_TOGGLE_TICKS = 3'd7
	} cfg_index_t;

	// Register reset values
	localparam logic [DutyW-1:0]  HighFullRst    = 7'd100;
	localparam logic [DutyW-1:0]  HighReducedRst = 7'd80;
	localparam logic [DutyW-1:0]  MidFullRst     = 7'd70;
	localparam logic [DutyW-1:0]  MidReducedRst  = 7'd55;
	localparam logic [DutyW-1:0]  LowFullRst     = 7'd40;
	localparam logic [DutyW-1:0]  LowReducedRst  = 7'd30;
	localparam logic [TicksW-1:0] StableTicksRst = 20'd900000;
	localparam logic [TicksW-1:0] ToggleTicksRst = 20'd15000;

	// Clamp a duty register value to the PWM period
	function automatic logic [DutyW-1:0] sat_duty(input logic [DutyW-1:0] d);
		logic [DutyW-1:0] r;
		r = (d > DutyMax) ? DutyMax : d;
		return r;
	endfunction

endpackage

[sv/heater_duty_sequencer.sv]
// Heater duty sequencer top level: command decode, timer and duty state.
// A transferred command passes the input register, then the state/result register.
// Throughput: one command per cycle unless out_stall holds the result; the one-pass
// decode and timer update set that figure.
// The state registers double as the result register, so a stalled result holds the state.
// Reset (arst_n low) clears all control state and loads register defaults at once.
`timescale 1ns / 1ps
`include "heater_duty_sequencer_assert.svh"

module heater_duty_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	// Command channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [hds_pkg::LevelW-1:0]         level_in,
	// Result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [hds_pkg::DutyW-1:0]          duty,
	output logic                               drive_enable,
	output logic                               heating_on,
	output logic [hds_pkg::LevelW-1:0]         level_out,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [hds_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [hds_pkg::TicksW-1:0]         cfg_data
);

	// Configuration registers
	logic [hds_pkg::DutyW-1:0]  high_full_q, high_reduced_q;
	logic [hds_pkg::DutyW-1:0]  mid_full_q, mid_reduced_q;
	logic [hds_pkg::DutyW-1:0]  low_full_q, low_reduced_q;
	logic [hds_pkg::TicksW-1:0] stable_ticks_q, toggle_ticks_q;

	// Input stage
	logic                        valid_s1;
	hds_pkg::opcode_t            opcode_s1;
	logic [hds_pkg::LevelW-1:0]  level_s1;

	// Sequencer state (also the result register)
	logic                        out_valid_q;
	logic                        on_q;
	hds_pkg::phase_t             phase_q;
	logic [hds_pkg::LevelW-1:0]  level_q;
	logic [hds_pkg::TicksW-1:0]  count_q;
	logic                        running_q;
	logic [hds_pkg::DutyW-1:0]   duty_q;
	logic                        enable_q;

	// Next state
	logic                        on_d;
	hds_pkg::phase_t             phase_d;
	logic [hds_pkg::LevelW-1:0]  level_d;
	logic [hds_pkg::TicksW-1:0]  count_d;
	logic                        running_d;
	logic [hds_pkg::DutyW-1:0]   duty_d;
	logic                        enable_d;

	logic                        advance;
	logic [hds_pkg::LevelW-1:0]  req_level;

	// Full or reduced duty register of a level
	function automatic logic [hds_pkg::DutyW-1:0] level_duty(
		input logic [hds_pkg::LevelW-1:0] lvl,
		input logic                       full
	);
		logic [hds_pkg::DutyW-1:0] d;
		if (lvl == hds_pkg::LVL_LOW) begin
			d = full ? low_full_q : low_reduced_q;
		end else if (lvl == hds_pkg::LVL_MID) begin
			d = full ? mid_full_q : mid_reduced_q;
		end else begin
			d = full ? high_full_q : high_reduced_q;
		end
		return d;
	endfunction

	// Handshake: the input stage moves on when the result slot is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_full_q    <= hds_pkg::HighFullRst;
			high_reduced_q <= hds_pkg::HighReducedRst;
			mid_full_q     <= hds_pkg::MidFullRst;
			mid_reduced_q  <= hds_pkg::MidReducedRst;
			low_full_q     <= hds_pkg::LowFullRst;
			low_reduced_q  <= hds_pkg::LowReducedRst;
			stable_ticks_q <= hds_pkg::StableTicksRst;
			toggle_ticks_q <= hds_pkg::ToggleTicksRst;
		end else if (cfg_we) begin
			case (hds_pkg::cfg_index_t'(cfg_index))
				hds_pkg::REG_HIGH_FULL:    high_full_q    <= cfg_data[hds_pkg::DutyW-1:0];
				hds_pkg::REG_HIGH_REDUCED: high_reduced_q <= cfg_data[hds_pkg::DutyW-1:0];
				hds_pkg::REG_MID_FULL:     mid_full_q     <= cfg_data[hds_pkg::DutyW-1:0];
				hds_pkg::REG_MID_REDUCED:  mid_reduced_q  <= cfg_data[hds_pkg::DutyW-1:0];
				hds_pkg::REG_LOW_FULL:     low_full_q     <= cfg_data[hds_pkg::DutyW-1:0];
				hds_pkg::REG_LOW_REDUCED:  low_reduced_q  <= cfg_data[hds_pkg::DutyW-1:0];
				hds_pkg::REG_STABLE_TICKS: stable_ticks_q <= cfg_data;
				hds_pkg::REG_TOGGLE_TICKS: toggle_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= hds_pkg::opcode_t'(opcode);
			level_s1  <= level_in;
		end
	end

	// Level 3 counts as high
	assign req_level = (level_s1 > hds_pkg::LVL_HIGH) ? hds_pkg::LVL_HIGH : level_s1;

	// Command decode and timer update
	always_comb begin
		on_d      = on_q;
		phase_d   = phase_q;
		level_d   = level_q;
		count_d   = count_q;
		running_d = running_q;
		duty_d    = duty_q;
		enable_d  = enable_q;
		case (opcode_s1)
			hds_pkg::OP_TICK: begin
				if (running_q) begin
					if (count_q <= 20'd1) begin
						count_d   = '0;
						running_d = 1'b0;
						// timer expiry: step the alternation
						if (phase_q == hds_pkg::PH_STABLE || phase_q == hds_pkg::PH_REDUCED) begin
							duty_d    = hds_pkg::sat_duty(level_duty(level_q, 1'b1));
							enable_d  = 1'b1;
							phase_d   = hds_pkg::PH_FULL;
							count_d   = toggle_ticks_q;
							running_d = 1'b1;
						end else if (phase_q == hds_pkg::PH_FULL) begin
							duty_d    = hds_pkg::sat_duty(level_duty(level_q, 1'b0));
							enable_d  = 1'b1;
							phase_d   = hds_pkg::PH_REDUCED;
							count_d   = toggle_ticks_q;
							running_d = 1'b1;
						end
					end else begin
						count_d = count_q - 20'd1;
					end
				end
			end
			hds_pkg::OP_ON: begin
				if (!on_q) begin
					on_d      = 1'b1;
					phase_d   = hds_pkg::PH_STABLE;
					level_d   = hds_pkg::LVL_HIGH;
					duty_d    = hds_pkg::sat_duty(high_full_q);
					enable_d  = 1'b1;
					count_d   = stable_ticks_q;
					running_d = 1'b1;
				end
			end
			hds_pkg::OP_OFF: begin
				if (on_q) begin
					on_d      = 1'b0;
					duty_d    = '0;
					enable_d  = 1'b0;
					running_d = 1'b0;
					count_d   = '0;
				end
			end
			hds_pkg::OP_LEVEL: begin
				// phase is kept, stable period restarts
				level_d   = req_level;
				duty_d    = hds_pkg::sat_duty(level_duty(req_level, 1'b1));
				enable_d  = 1'b1;
				count_d   = stable_ticks_q;
				running_d = 1'b1;
			end
			default: ;
		endcase
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			on_q        <= 1'b0;
			phase_q     <= hds_pkg::PH_IDLE;
			level_q     <= hds_pkg::LVL_HIGH;
			count_q     <= '0;
			running_q   <= 1'b0;
			duty_q      <= '0;
			enable_q    <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				on_q        <= on_d;
				phase_q     <= phase_d;
				level_q     <= level_d;
				count_q     <= count_d;
				running_q   <= running_d;
				duty_q      <= duty_d;
				enable_q    <= enable_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign duty         = duty_q;
	assign drive_enable = enable_q;
	assign heating_on   = on_q;
	assign level_out    = level_q;

	// Checks
	`HDS_ASSERT_IMPLIES(a_off_zero_duty, !enable_q, duty_q == '0)
	`HDS_ASSERT_ALWAYS(a_level_legal, level_q <= hds_pkg::LVL_HIGH)
	`HDS_ASSERT_IMPLIES(a_stopped_timer_clear, !running_q, count_q == '0)
	`HDS_ASSERT_IMPLIES(a_on_not_idle, on_q, phase_q != hds_pkg::PH_IDLE)

endmodule
